/* src/htsu_pkg.sv */
// shared types and constants of the hex text septet unpacker
package htsu_pkg;

	localparam int CFG_AW = 3;
	localparam logic [CFG_AW-1:0] ADDR_MAX_OUT = 3'd0;
	localparam logic [15:0] MAX_OUT_RESET = 16'd161;

	localparam logic [7:0] DIGIT_LO = 8'h30;
	localparam logic [7:0] DIGIT_HI = 8'h39;
	localparam logic [7:0] CASE_BIT = 8'h20;
	localparam logic [7:0] ALPHA_LO = 8'h41;
	localparam logic [7:0] ALPHA_HI = 8'h46;
	localparam logic [3:0] ALPHA_OFS = 4'd9;

	localparam logic [2:0] POS_LAST_PAIR = 3'd6;
	localparam logic [2:0] POS_NONE = 3'd7;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);
	localparam logic [FIFO_AW:0] FIFO_ROOM_MAX = (FIFO_AW + 1)'(FIFO_DEPTH - 2);

	typedef struct packed {
		logic [6:0] septet;
		logic       char_valid;
		logic       bad_char;
		logic       buffer_full;
		logic       message_done;
	} result_t;

	typedef struct packed {
		logic [1:0] cnt;
		result_t    r0;
		result_t    r1;
	} push_t;

endpackage

/* src/htsu_if.sv */
// item channel interfaces of the hex text septet unpacker
interface htsu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] pdu_char;
	logic       end_of_message;

	modport source (output valid, output pdu_char, output end_of_message, input ready);
	modport sink (input valid, input pdu_char, input end_of_message, output ready);
endinterface

interface htsu_out_if;
	logic       valid;
	logic       ready;
	logic [6:0] septet;
	logic       char_valid;
	logic       bad_char;
	logic       buffer_full;
	logic       message_done;

	modport source (output valid, output septet, output char_valid, output bad_char,
		output buffer_full, output message_done, input ready);
	modport sink (input valid, input septet, input char_valid, input bad_char,
		input buffer_full, input message_done, output ready);
endinterface

/* src/htsu_cfg.sv */
// apb register file holding max_out
module htsu_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [htsu_pkg::CFG_AW-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output logic [15:0]                max_out
);
	import htsu_pkg::*;

	logic [15:0] max_out_q;
	logic        hit;

	assign hit = (paddr == ADDR_MAX_OUT);
	assign pready = 1'b1;
	assign max_out = max_out_q;
	assign prdata = hit ? {16'd0, max_out_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_out_q <= MAX_OUT_RESET;
		end else if (psel && penable && pwrite && pready && hit) begin
			max_out_q <= pwdata[15:0];
		end
	end
endmodule

/* src/htsu_core.sv */
// input register, nibble pairing, septet unpacking and message state
module htsu_core (
	input  logic            clk,
	input  logic            arst_n,
	htsu_in_if.sink         in_ch,
	input  logic [15:0]     max_out,
	input  logic            room,
	output htsu_pkg::push_t push
);
	import htsu_pkg::*;

	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        eom_s1;

	logic        stopped_q;
	logic        phase_q;
	logic [7:0]  cur_q;
	logic [7:0]  prev_q;
	logic [15:0] cnt_q;

	logic        advance;
	logic        is_digit;
	logic        is_alpha;
	logic        is_hex;
	logic [7:0]  upper;
	logic [3:0]  nib;
	logic [7:0]  new_cur;
	logic [2:0]  pos;
	logic [15:0] pair;
	logic [15:0] shifted;
	logic        no_room1;
	logic        room2;

	logic        stopped_d;
	logic        phase_d;
	logic [7:0]  cur_d;
	logic [7:0]  prev_d;
	logic [15:0] cnt_d;
	push_t       push_d;

	assign advance = valid_s1 && room;
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			char_s1 <= in_ch.pdu_char;
			eom_s1 <= in_ch.end_of_message;
		end
	end

	assign upper = char_s1 & ~CASE_BIT;
	assign is_digit = (char_s1 >= DIGIT_LO) && (char_s1 <= DIGIT_HI);
	assign is_alpha = (upper >= ALPHA_LO) && (upper <= ALPHA_HI);
	assign is_hex = is_digit || is_alpha;
	assign nib = is_digit ? char_s1[3:0] : upper[3:0] + ALPHA_OFS;
	assign new_cur = {cur_q[3:0], nib};
	assign pos = cnt_q[2:0];
	assign pair = {new_cur, prev_q};
	assign shifted = pair >> (4'd8 - {1'b0, pos});
	assign no_room1 = ({1'b0, cnt_q} + 17'd1) >= {1'b0, max_out};
	assign room2 = ({1'b0, cnt_q} + 17'd2) < {1'b0, max_out};

	always_comb begin
		stopped_d = stopped_q;
		phase_d = phase_q;
		cur_d = cur_q;
		prev_d = prev_q;
		cnt_d = cnt_q;
		push_d = '0;
		if (!stopped_q) begin
			if (!is_hex) begin
				push_d.cnt = 2'd1;
				push_d.r0.bad_char = 1'b1;
				stopped_d = 1'b1;
			end else begin
				cur_d = new_cur;
				phase_d = ~phase_q;
				if (phase_q) begin
					prev_d = new_cur;
					if (no_room1) begin
						push_d.cnt = 2'd1;
						push_d.r0.buffer_full = 1'b1;
						stopped_d = 1'b1;
					end else if (pos != POS_NONE) begin
						push_d.cnt = 2'd1;
						push_d.r0.septet = shifted[6:0];
						push_d.r0.char_valid = 1'b1;
						cnt_d = cnt_q + 16'd1;
						if (pos == POS_LAST_PAIR && room2) begin
							push_d.cnt = 2'd2;
							push_d.r1.septet = new_cur[7:1];
							push_d.r1.char_valid = 1'b1;
							cnt_d = cnt_q + 16'd2;
						end
					end
				end
			end
		end
		if (eom_s1) begin
			case (push_d.cnt)
				2'd0: begin
					push_d.cnt = 2'd1;
					push_d.r0.message_done = 1'b1;
				end
				2'd1: push_d.r0.message_done = 1'b1;
				2'd2: push_d.r1.message_done = 1'b1;
				default: push_d.r0.message_done = 1'b1;
			endcase
			stopped_d = 1'b0;
			phase_d = 1'b0;
			cur_d = '0;
			prev_d = '0;
			cnt_d = '0;
		end
		if (!advance) begin
			push_d.cnt = 2'd0;
		end
	end

	assign push = push_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stopped_q <= 1'b0;
			phase_q <= 1'b0;
			cur_q <= '0;
			prev_q <= '0;
			cnt_q <= '0;
		end else if (advance) begin
			stopped_q <= stopped_d;
			phase_q <= phase_d;
			cur_q <= cur_d;
			prev_q <= prev_d;
			cnt_q <= cnt_d;
		end
	end
endmodule

/* src/htsu_fifo.sv */
// result queue taking up to two items per cycle and giving one while out_ch is ready
module htsu_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  htsu_pkg::push_t push,
	output logic            room,
	htsu_out_if.source      out_ch
);
	import htsu_pkg::*;

	result_t              mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_AW:0]     count_q;
	logic [FIFO_AW-1:0]   wr_next;
	logic                 pop;
	result_t              head;

	assign wr_next = wr_ptr_q + 1'b1;
	assign pop = out_ch.valid && out_ch.ready;
	assign room = count_q <= FIFO_ROOM_MAX;
	assign head = mem_q[rd_ptr_q];

	assign out_ch.valid = count_q != '0;
	assign out_ch.septet = head.septet;
	assign out_ch.char_valid = head.char_valid;
	assign out_ch.bad_char = head.bad_char;
	assign out_ch.buffer_full = head.buffer_full;
	assign out_ch.message_done = head.message_done;

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wr_next] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push.cnt[FIFO_AW-1:0];
			rd_ptr_q <= rd_ptr_q + {{(FIFO_AW-1){1'b0}}, pop};
			count_q <= count_q + {{(FIFO_AW-1){1'b0}}, push.cnt}
				- {{FIFO_AW{1'b0}}, pop};
		end
	end
endmodule

/* src/hex_text_septet_unpacker.sv */
// top level of the hex text septet unpacker
//
// in_ch takes one ascii character of a hex pdu text per item, with
// end_of_message on the last one. nibbles pair into bytes, high first, and
// each byte is unpacked with the byte before it into gsm 7-bit septets.
// out_ch gives one result item per septet, or a status item for a non-hex
// character, for reaching max_out, or for an end item with nothing else.
// max_out is written over the apb port, byte address 0, reset value 161.
// an item is accepted in every cycle while the queue has room; the input
// register feeds one pass of decode logic that pushes up to two results into
// a four-entry queue, and the queue drains one result per cycle while out_ch
// is ready, so a sustained rate of one item per cycle holds while items give
// at most one result each. a first result passes the input register and the
// queue before it shows on out_ch.
// when out_ch stalls the queue fills and in_ch.ready drops once fewer than
// two entries are free; nothing is lost. reset clears the message state
// and the queue and sets max_out to 161; the block is ready out of reset.
module hex_text_septet_unpacker (
	input  logic                        clk,
	input  logic                        arst_n,
	htsu_in_if.sink                     in_ch,
	htsu_out_if.source                  out_ch,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [htsu_pkg::CFG_AW-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import htsu_pkg::*;

	logic [15:0] max_out;
	logic        room;
	push_t       push;

	htsu_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.max_out (max_out)
	);

	htsu_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.max_out (max_out),
		.room    (room),
		.push    (push)
	);

	htsu_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.out_ch (out_ch)
	);
endmodule

/* src/htsu_checker.sv */
// port checker for the hex text septet unpacker and its bind
module htsu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [6:0] septet,
	input logic       char_valid,
	input logic       bad_char,
	input logic       buffer_full,
	input logic       message_done,
	input logic       pready
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(septet) && $stable(char_valid)
			&& $stable(bad_char) && $stable(buffer_full) && $stable(message_done))
		else $error("result item changed while stalled");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0({char_valid, bad_char, buffer_full}))
		else $error("result item carries more than one kind");

	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !char_valid |-> septet == 7'd0)
		else $error("status item with nonzero septet");

	a_empty_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !char_valid && !bad_char && !buffer_full |-> message_done)
		else $error("empty result item without message end");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("apb port not ready");
endmodule

bind hex_text_septet_unpacker htsu_checker u_htsu_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.septet       (out_ch.septet),
	.char_valid   (out_ch.char_valid),
	.bad_char     (out_ch.bad_char),
	.buffer_full  (out_ch.buffer_full),
	.message_done (out_ch.message_done),
	.pready       (pready)
);
